// ===== design/aecp_pkg.sv =====
package aecp_pkg;

  // Sizes of bytes, cursor, values, status and register index
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 8;
  localparam int VAL_W   = 14;
  localparam int STAT_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_PARAMETERS_DEF = 16;

  // Parameter values saturate here
  localparam logic [VAL_W-1:0] VALUE_MAX = VAL_W'(9999);

  // Console size after reset
  localparam logic [POS_W-1:0] WIDTH_RST  = POS_W'(80);
  localparam logic [POS_W-1:0] HEIGHT_RST = POS_W'(25);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

  // Result status codes
  localparam logic [STAT_W-1:0] ST_IDLE = 3'd0;
  localparam logic [STAT_W-1:0] ST_BUSY = 3'd1;
  localparam logic [STAT_W-1:0] ST_EXEC = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOOP = 3'd3;
  localparam logic [STAT_W-1:0] ST_SAVE = 3'd4;
  localparam logic [STAT_W-1:0] ST_ERR  = 3'd5;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UP    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_DOWN  = 8'h42;
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h43;
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h44;
  localparam logic [BYTE_W-1:0] CH_POS   = 8'h48;
  localparam logic [BYTE_W-1:0] CH_ERASE = 8'h4A;
  localparam logic [BYTE_W-1:0] CH_ATTR  = 8'h6D;
  localparam logic [BYTE_W-1:0] CH_SAVE  = 8'h73;
  localparam logic [BYTE_W-1:0] CH_REST  = 8'h75;

  // Only an erase with this parameter is accepted
  localparam logic [VAL_W-1:0] ERASE_ALL = VAL_W'(2);

  // One byte held between the input register and the parser
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } beat_t;

endpackage

// ===== design/ansi_escape_cursor_parser.sv =====
// An accepted beat passes the input register, then the result register.
// Throughput: one byte per cycle while the result is not stalled; each byte
// is decoded by one pass of logic between input and result registers.
// Reset (synchronous, rst high): parser idle, cursor and saved cursor at 0,
// console 80 columns by 25 rows, no result pending.
module ansi_escape_cursor_parser import aecp_pkg::*; #(
  parameter int MAX_PARAMETERS = MAX_PARAMETERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAT_W-1:0]    status,
  output logic [POS_W-1:0]     cur_col,
  output logic [POS_W-1:0]     cur_row
);

  beat_t beat;
  logic  take;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  aecp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .take     (take),
    .beat     (beat)
  );

  aecp_core #(
    .MAX_PARAMETERS (MAX_PARAMETERS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .take      (take),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cur_col   (cur_col),
    .cur_row   (cur_row)
  );

endmodule

// ===== design/aecp_in_stage.sv =====
module aecp_in_stage import aecp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              take,
  output beat_t             beat
);

  logic              held;
  logic [BYTE_W-1:0] data;

  // Stall only while a held beat cannot move on
  assign in_stall = held && !take;

  assign beat.valid = held;
  assign beat.data  = data;

  // Load a new beat whenever the slot is free or drains this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
    if (!in_stall && in_valid) begin
      data <= in_byte;
    end
  end

endmodule

// ===== design/aecp_core.sv =====
module aecp_core import aecp_pkg::*; #(
  parameter int MAX_PARAMETERS = MAX_PARAMETERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  beat_t                beat,
  output logic                 take,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAT_W-1:0]    status,
  output logic [POS_W-1:0]     cur_col,
  output logic [POS_W-1:0]     cur_row
);

  localparam int CNT_W = $clog2(MAX_PARAMETERS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_PARAMETERS - 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_ZERO = '0;

  typedef enum logic [2:0] {
    M_IDLE,
    M_ESC,
    M_CSI,
    M_PARAM,
    M_ERROR
  } mode_t;

  mode_t             mode, mode_next;
  logic [CNT_W-1:0]  pcount, pcount_next;
  logic [VAL_W-1:0]  first_param, first_param_next;
  logic              first_absent, first_absent_next;
  logic [VAL_W-1:0]  second_param, second_param_next;
  logic [VAL_W-1:0]  bval, bval_next;
  logic              attr_ok, attr_ok_next;
  logic [POS_W-1:0]  col, col_next, row, row_next;
  logic [POS_W-1:0]  saved_col, saved_col_next, saved_row, saved_row_next;
  logic [POS_W-1:0]  width, height;
  logic [STAT_W-1:0] st;

  logic              advance;
  logic [BYTE_W-1:0] c;
  logic              digit;
  logic [POS_W-1:0]  wl, hl;
  logic [VAL_W-1:0]  p0, p1, p0m1, p1m1;
  logic [VAL_W:0]    row_sum, col_sum;
  logic [16:0]       acc;

  function automatic logic attr_valid(input logic [VAL_W-1:0] v);
    return v inside {[0:2], [30:37], [40:47]};
  endfunction

  // Accept from the input register when the result slot is free or drains
  assign take    = !out_valid || !out_stall;
  assign advance = beat.valid && take;

  assign cur_col = col;
  assign cur_row = row;

  assign c     = beat.data;
  assign digit = c inside {[CH_ZERO:CH_NINE]};
  assign wl    = (width == '0) ? '0 : width - POS_W'(1);
  assign hl    = (height == '0) ? '0 : height - POS_W'(1);

  // Parameters as a terminator on this byte sees them
  assign p0 = (pcount == CNT_ZERO) ? bval : (first_absent ? '0 : first_param);
  assign p1 = (pcount == CNT_ONE) ? bval : second_param;
  assign p0m1 = p0 - VAL_W'(1);
  assign p1m1 = p1 - VAL_W'(1);
  assign row_sum = {{(VAL_W + 1 - POS_W){1'b0}}, row} + {1'b0, p0};
  assign col_sum = {{(VAL_W + 1 - POS_W){1'b0}}, col} + {1'b0, p0};
  assign acc = 17'(bval) * 17'd10 + 17'(c[3:0]);

  // Decode one byte against the parse mode
  always_comb begin
    mode_next         = mode;
    pcount_next       = pcount;
    first_param_next  = first_param;
    first_absent_next = first_absent;
    second_param_next = second_param;
    bval_next         = bval;
    attr_ok_next      = attr_ok;
    col_next          = col;
    row_next          = row;
    saved_col_next    = saved_col;
    saved_row_next    = saved_row;
    st                = ST_ERR;

    case (mode)
      M_IDLE: begin
        if (c == CH_ESC) begin
          pcount_next       = '0;
          first_param_next  = '0;
          first_absent_next = 1'b1;
          second_param_next = '0;
          bval_next         = '0;
          attr_ok_next      = 1'b1;
          mode_next         = M_ESC;
          st                = ST_BUSY;
        end else begin
          st = ST_IDLE;
        end
      end
      M_ESC: begin
        if (c == CH_LBRK) begin
          mode_next = M_CSI;
          st        = ST_BUSY;
        end else begin
          mode_next = M_ERROR;
        end
      end
      M_CSI: begin
        if (digit) begin
          bval_next = VAL_W'(c[3:0]);
          mode_next = M_PARAM;
          st        = ST_BUSY;
        end else if (c == CH_SAVE) begin
          saved_col_next = col;
          saved_row_next = row;
          mode_next      = M_IDLE;
          st             = ST_SAVE;
        end else if (c == CH_REST) begin
          col_next  = saved_col;
          row_next  = saved_row;
          mode_next = M_IDLE;
          st        = ST_SAVE;
        end else if (c == CH_SEMI) begin
          // Empty first parameter: open the second one
          attr_ok_next      = 1'b0;
          first_absent_next = 1'b1;
          pcount_next       = CNT_ONE;
          bval_next         = '0;
          mode_next         = M_PARAM;
          st                = ST_BUSY;
        end else if (c == CH_UP || c == CH_DOWN) begin
          mode_next = M_IDLE;
          st        = ST_NOOP;
        end else begin
          mode_next = M_ERROR;
        end
      end
      M_PARAM: begin
        if (digit) begin
          bval_next = (acc > 17'(VALUE_MAX)) ? VALUE_MAX : acc[VAL_W-1:0];
          st        = ST_BUSY;
        end else begin
          mode_next = M_IDLE;
          case (c)
            CH_SEMI: begin
              if (pcount >= CNT_LAST) begin
                mode_next = M_ERROR;
              end else begin
                if (!attr_valid(bval)) begin
                  attr_ok_next = 1'b0;
                end
                if (pcount == CNT_ZERO) begin
                  first_param_next  = bval;
                  first_absent_next = 1'b0;
                end else if (pcount == CNT_ONE) begin
                  second_param_next = bval;
                end
                pcount_next = pcount + CNT_ONE;
                bval_next   = '0;
                mode_next   = M_PARAM;
                st          = ST_BUSY;
              end
            end
            CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT: begin
              if (p0 == '0) begin
                st = ST_NOOP;
              end else begin
                st = ST_EXEC;
                case (c)
                  CH_UP: begin
                    row_next = ({{(VAL_W - POS_W){1'b0}}, row} > p0) ?
                               row - p0[POS_W-1:0] : '0;
                  end
                  CH_DOWN: begin
                    row_next = (row_sum > (VAL_W + 1)'(hl)) ? hl : row_sum[POS_W-1:0];
                  end
                  CH_RIGHT: begin
                    col_next = (col_sum > (VAL_W + 1)'(wl)) ? wl : col_sum[POS_W-1:0];
                  end
                  default: begin
                    col_next = ({{(VAL_W - POS_W){1'b0}}, col} > p0) ?
                               col - p0[POS_W-1:0] : '0;
                  end
                endcase
              end
            end
            CH_POS: begin
              if (p0 != '0) begin
                row_next = (p0m1 > VAL_W'(hl)) ? hl : p0m1[POS_W-1:0];
              end
              if (pcount != CNT_ZERO && p1 != '0) begin
                col_next = (p1m1 > VAL_W'(wl)) ? wl : p1m1[POS_W-1:0];
              end
              st = ST_EXEC;
            end
            CH_ERASE: begin
              if (pcount == CNT_ZERO && bval == ERASE_ALL) begin
                col_next = '0;
                row_next = '0;
                st       = ST_EXEC;
              end else begin
                mode_next = M_ERROR;
              end
            end
            CH_ATTR: begin
              if (attr_ok && attr_valid(bval)) begin
                st = ST_EXEC;
              end else begin
                mode_next = M_ERROR;
              end
            end
            CH_SAVE: begin
              saved_col_next = col;
              saved_row_next = row;
              st             = ST_SAVE;
            end
            CH_REST: begin
              col_next = saved_col;
              row_next = saved_row;
              st       = ST_SAVE;
            end
            default: begin
              mode_next = M_ERROR;
            end
          endcase
        end
      end
      default: begin
        mode_next = M_ERROR;
      end
    endcase

    // Error is sticky and always reports as such
    if (mode_next == M_ERROR) begin
      st = ST_ERR;
    end
  end

  // Hold parse state, cursor, console size and the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      pcount       <= '0;
      first_param  <= '0;
      first_absent <= 1'b1;
      second_param <= '0;
      bval         <= '0;
      attr_ok      <= 1'b1;
      col          <= '0;
      row          <= '0;
      saved_col    <= '0;
      saved_row    <= '0;
      width        <= WIDTH_RST;
      height       <= HEIGHT_RST;
      out_valid    <= 1'b0;
      status       <= ST_IDLE;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WIDTH:  width  <= cfg_data;
          CFG_HEIGHT: height <= cfg_data;
          default: ;
        endcase
      end
      if (advance) begin
        mode         <= mode_next;
        pcount       <= pcount_next;
        first_param  <= first_param_next;
        first_absent <= first_absent_next;
        second_param <= second_param_next;
        bval         <= bval_next;
        attr_ok      <= attr_ok_next;
        col          <= col_next;
        row          <= row_next;
        saved_col    <= saved_col_next;
        saved_row    <= saved_row_next;
        status       <= st;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/aecp_checker.sv =====
module aecp_checker import aecp_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] status,
  input logic [POS_W-1:0]  cur_col,
  input logic [POS_W-1:0]  cur_row
);

  // Input backs up only behind a pending, stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // Cursor never passes the largest console limit
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cur_col != 8'hFF && cur_row != 8'hFF))
    else $error("cursor outside console range");

  // Status carries a defined code only
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_ERR))
    else $error("undefined status code");

  // No result is left over from before reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) &&
                                  $stable(cur_col) && $stable(cur_row)))
    else $error("stalled result changed");

endmodule

bind ansi_escape_cursor_parser aecp_checker u_aecp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .cur_col   (cur_col),
  .cur_row   (cur_row)
);
